// ===== rtl/core/slv_pkg.sv =====
// ----------------------------------------------------------------------------
// slv_pkg
// Shared types and constants of the scanline luma displacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package slv_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MAX_SPACING = 64;

  localparam int LUMA_W = 8;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 11;
  localparam int PH_W   = 6;
  localparam int FW_W   = 12;
  localparam int FH_W   = 12;
  localparam int SP_W   = 7;
  localparam int DIV_W  = 8;
  localparam int ADDR_W = 22;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = FH_W'(480);
  localparam logic [SP_W-1:0]  LINE_SPACING_RST = SP_W'(10);
  localparam logic [DIV_W-1:0] GAIN_DIVISOR_RST = DIV_W'(30);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_AW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LINE_SPACING = 2'd2,
    CFG_GAIN_DIVISOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SUB,
    BK_ADDR
  } bk_state_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [FW_W-1:0]  width;
    logic [FH_W-1:0]  height;
    logic [SP_W-1:0]  spacing;
    logic [DIV_W-1:0] divisor;
  } slv_cfg_t;

  // one pixel of a drawn line, handed from front to back
  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } slv_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } slv_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/scanline_luma_displacement.sv =====
// ----------------------------------------------------------------------------
// scanline_luma_displacement
// Raster luma in, frame buffer write addresses of displaced white dots out.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order while in_stall_o is low.
// Pixels on lines that are not drawn give no result. Each pixel of a drawn
// line goes into a four-entry queue, then a one-bit-per-cycle divider. The
// back end takes a new pixel only when done with the last one (fetch, divide,
// row subtract, address multiply); in_stall_o rises whenever the queue is full.
// Configuration writes are always taken (cfg_ready_o is tied high) and must be
// done while the block is idle. Register values of 0 act as 1; width and
// height clamp to 2048, spacing to 64.
`default_nettype none

module scanline_luma_displacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  luma_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] write_address_o,
  output logic [10:0] plot_column_o,
  output logic [10:0] plot_row_o
);
  import slv_pkg::*;

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [SP_W-1:0]  sp_q;
  logic [DIV_W-1:0] div_q;
  slv_cfg_t         cfg;
  slv_qstat_t       qstat;
  slv_item_t        push_item, head;
  logic             push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FRAME_WIDTH_RST;
      fh_q  <= FRAME_HEIGHT_RST;
      sp_q  <= LINE_SPACING_RST;
      div_q <= GAIN_DIVISOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q  <= cfg_data_i[FH_W-1:0];
        CFG_LINE_SPACING: sp_q  <= cfg_data_i[SP_W-1:0];
        CFG_GAIN_DIVISOR: div_q <= cfg_data_i[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width   = (fw_q == '0) ? FW_W'(1) :
                  (fw_q > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_q;
    cfg.height  = (fh_q == '0) ? FH_W'(1) :
                  (fh_q > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_q;
    cfg.spacing = (sp_q == '0) ? SP_W'(1) :
                  (sp_q > SP_W'(MAX_SPACING)) ? SP_W'(MAX_SPACING) : sp_q;
    cfg.divisor = (div_q == '0) ? DIV_W'(1) : div_q;
  end

  slv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .luma_i       (luma_i),
    .frame_start_i(frame_start_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  slv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  slv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .qstat_i        (qstat),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_address_o(write_address_o),
    .plot_column_o  (plot_column_o),
    .plot_row_o     (plot_row_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/slv_front.sv =====
// ----------------------------------------------------------------------------
// slv_front
// Pixel intake: column, row and spacing phase counters, picks drawn pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slv_pkg::slv_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         luma_i,
  input  logic               frame_start_i,
  input  slv_pkg::slv_qstat_t qstat_i,
  output logic               push_o,
  output slv_pkg::slv_item_t push_item_o
);
  import slv_pkg::*;

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [PH_W-1:0]  ph_q, ph_d, ph_cur;
  logic             accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    ph_cur  = frame_start_i ? '0 : ph_q;

    col_d = col_cur;
    row_d = row_cur;
    ph_d  = ph_cur;
    if (({1'b0, col_cur} + FW_W'(1)) >= cfg_i.width) begin
      col_d = '0;
      if (({1'b0, row_cur} + FH_W'(1)) >= cfg_i.height) begin
        // last row of the frame: start over as on a new frame
        row_d = '0;
        ph_d  = '0;
      end else begin
        row_d = row_cur + ROW_W'(1);
        if (({1'b0, ph_cur} + SP_W'(1)) >= cfg_i.spacing) begin
          ph_d = '0;
        end else begin
          ph_d = ph_cur + PH_W'(1);
        end
      end
    end else begin
      col_d = col_cur + COL_W'(1);
    end
  end

  assign push_o           = accept & (ph_cur == '0);
  assign push_item_o.luma = luma_i;
  assign push_item_o.col  = col_cur;
  assign push_item_o.row  = row_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ph_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      ph_q  <= ph_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/slv_fifo.sv =====
// ----------------------------------------------------------------------------
// slv_fifo
// Short queue of drawn pixels between intake and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slv_pkg::slv_item_t  push_item_i,
  input  logic                pop_i,
  output slv_pkg::slv_item_t  head_o,
  output slv_pkg::slv_qstat_t qstat_o
);
  import slv_pkg::*;

  slv_item_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]    cnt_q;
  logic                 do_push, do_pop;

  assign qstat_o.full  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/slv_back.sv =====
// ----------------------------------------------------------------------------
// slv_back
// Divides luma by the gain, displaces the row and forms the write address.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slv_pkg::slv_cfg_t   cfg_i,
  input  slv_pkg::slv_qstat_t qstat_i,
  input  slv_pkg::slv_item_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [21:0]         write_address_o,
  output logic [10:0]         plot_column_o,
  output logic [10:0]         plot_row_o
);
  import slv_pkg::*;

  localparam int CNT_W = $clog2(LUMA_W);

  bk_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_W-1:0]  rem_q;
  logic [LUMA_W-1:0] quo_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  row_new_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COL_W-1:0]  pcol_q;
  logic [ROW_W-1:0]  prow_q;

  logic [DIV_W:0]    rem_sh, rem_nx;
  logic              ge;
  logic              hit;
  logic [ROW_W-1:0]  row_new;
  logic [ROW_W+FW_W-1:0] prod;
  logic [ROW_W+FW_W-1:0] addr_full;
  logic              load;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[LUMA_W-1]};
    ge     = rem_sh >= {1'b0, cfg_i.divisor};
    rem_nx = ge ? (rem_sh - {1'b0, cfg_i.divisor}) : rem_sh;
  end

  assign hit       = {{(ROW_W-LUMA_W){1'b0}}, quo_q} <= row_q;
  assign row_new   = row_q - {{(ROW_W-LUMA_W){1'b0}}, quo_q};
  assign prod      = row_new_q * cfg_i.width;
  assign addr_full = prod + {{(ROW_W+FW_W-COL_W){1'b0}}, col_q};

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == CNT_W'(LUMA_W-1)) begin
          state_d = BK_SUB;
        end
      end
      BK_SUB: begin
        // lifted above the top of the frame: nothing to paint
        state_d = hit ? BK_ADDR : BK_IDLE;
      end
      BK_ADDR: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q <= '0;
      quo_q <= head_i.luma;
      col_q <= head_i.col;
      row_q <= head_i.row;
    end else if (state_q == BK_DIV) begin
      rem_q <= rem_nx[DIV_W-1:0];
      quo_q <= {quo_q[LUMA_W-2:0], ge};
    end
    if (state_q == BK_SUB) begin
      row_new_q <= row_new;
    end
    if (load) begin
      addr_q <= addr_full[ADDR_W-1:0];
      pcol_q <= col_q;
      prow_q <= row_new_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign plot_column_o   = pcol_q;
  assign plot_row_o      = prow_q;

endmodule

`default_nettype wire

// ===== rtl/core/slv_checker.sv =====
// ----------------------------------------------------------------------------
// slv_checker
// Port-level checks of the scanline luma displacement block.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [21:0] write_address_o,
  input logic [10:0] plot_column_o,
  input logic [10:0] plot_row_o
);

  // nothing to deliver while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // address is column plus a multiple of the width, never below the column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_address_o >= {11'd0, plot_column_o}))
    else $error("write address below plot column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(write_address_o) && $stable(plot_column_o) && $stable(plot_row_o))
    else $error("stalled result changed");

endmodule

bind scanline_luma_displacement slv_checker u_slv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .write_address_o(write_address_o),
  .plot_column_o  (plot_column_o),
  .plot_row_o     (plot_row_o)
);

`default_nettype wire
